[sv/igta_pkg.sv]
// Shared types, constants and helpers for the idle gate time attribution block.
`default_nettype none

package igta_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_BLOCKERS_DEF = 7;
  localparam int TIME_BITS_DEF    = 48;

  // Field widths
  localparam int BLK_W     = 3;
  localparam int COND_W    = 6;
  localparam int DUE_W     = 16;
  localparam int PARK_W    = 10;
  localparam int CNT_W     = 32;
  localparam int PCT_W     = 7;
  localparam int THR_W     = 10;
  localparam int GAP_W     = 26;
  localparam int SPAN_W    = 20;
  localparam int STEP_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 26;
  localparam int OUT_W     = 72;

  // Blocker codes
  localparam logic [BLK_W-1:0] BLK_DISABLED = 3'd0;
  localparam logic [BLK_W-1:0] BLK_PASS     = 3'd7;

  localparam logic [PARK_W-1:0] MAX_PARK_MS = 10'd1000;
  localparam int                US_PER_MS   = 1000;
  localparam logic [PCT_W-1:0]  PCT_FULL    = 7'd100;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP  = 2'd2;

  localparam logic [THR_W-1:0] THROTTLE_RST = 10'd50;
  localparam logic [GAP_W-1:0] MAX_GAP_RST  = 26'd5000000;

  // Datapath micro-operations
  typedef enum logic [3:0] {
    U_NOP,
    U_RD_BLK,
    U_CHK,
    U_ADD,
    U_PARK,
    U_SPAN,
    U_COMMIT,
    U_SC_RD,
    U_SC_CMP,
    U_Q_RD,
    U_P1_LD,
    U_DIV,
    U_P1_ST,
    U_P2_LD,
    U_P2_ST,
    U_EMIT
  } uop_e;

  // Jump conditions of the sequencer
  typedef enum logic [2:0] {
    J_NONE,
    J_ALWAYS,
    J_NO_START,
    J_SCAN_MORE,
    J_DIV_BUSY,
    J_OUT_FULL
  } jcond_e;

  typedef struct packed {
    uop_e              op;
    jcond_e            jc;
    logic [STEP_W-1:0] target;
  } ucw_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic div_busy;
    logic scan_more;
  } dp_stat_t;

  // One result item
  typedef struct packed {
    logic [PCT_W-1:0]  asleep_pct;
    logic [BLK_W-1:0]  top_blocker;
    logic [PCT_W-1:0]  blocked_pct;
    logic              wake_reason;
    logic [CNT_W-1:0]  park_count;
    logic              parked;
    logic              entering_park;
    logic              transition_valid;
    logic [PARK_W-1:0] park_ms;
    logic [BLK_W-1:0]  blocker;
  } res_t;

  // Priority gate: first condition that is not met blocks
  function automatic logic [BLK_W-1:0] gate(input logic en, input logic [COND_W-1:0] cond);
    logic [BLK_W-1:0] blk;
    blk = BLK_PASS;
    for (int i = COND_W - 1; i >= 0; i--) begin
      if (!cond[i]) blk = BLK_W'(i + 1);
    end
    if (!en) blk = BLK_DISABLED;
    return blk;
  endfunction

endpackage

`default_nettype wire

[sv/igta_pdiv.sv]
// Bit-serial percentage unit: floor(num*100/den), capped at 100.
`default_nettype none

module igta_pdiv import igta_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 ld_i,
  input  wire logic                 step_i,
  input  wire logic [TIME_BITS-1:0] num_i,
  input  wire logic [TIME_BITS-1:0] den_i,
  output logic                      busy_o,
  output logic [PCT_W-1:0]          pct_o
);

  localparam int NW = TIME_BITS + PCT_W;

  logic [NW-1:0]    rem_q;
  logic [NW-1:0]    dvs_q;
  logic [PCT_W-1:0] quo_q;
  logic [2:0]       cnt_q;
  logic [NW-1:0]    num_ext;
  logic             fits;

  assign num_ext = NW'(num_i);
  assign fits    = rem_q >= dvs_q;

  // count of quotient bits left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ld_i) begin
      cnt_q <= (den_i == '0 || num_i >= den_i) ? 3'd0 : 3'(PCT_W);
    end else if (step_i && cnt_q != '0) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      // times 100 as 64 + 32 + 4
      rem_q <= (num_ext << 6) + (num_ext << 5) + (num_ext << 2);
      dvs_q <= NW'(den_i) << (PCT_W - 1);
      if (den_i == '0) quo_q <= '0;
      else if (num_i >= den_i) quo_q <= PCT_FULL;
      else quo_q <= '0;
    end else if (step_i && cnt_q != '0) begin
      if (fits) rem_q <= rem_q - dvs_q;
      dvs_q <= dvs_q >> 1;
      quo_q <= {quo_q[PCT_W-2:0], fits};
    end
  end

  assign busy_o = cnt_q != '0;
  assign pct_o  = quo_q;

endmodule

`default_nettype wire

[sv/igta_seq.sv]
// Microcode sequencer: step counter, control ROM and conditional jumps.
`default_nettype none

module igta_seq import igta_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire logic     out_full_i,
  input  wire dp_stat_t stat_i,
  output uop_e          op_o,
  output logic          idle_o
);

  localparam logic [STEP_W-1:0] S_IDLE   = 5'd0;
  localparam logic [STEP_W-1:0] S_RD_BLK = 5'd1;
  localparam logic [STEP_W-1:0] S_CHK    = 5'd2;
  localparam logic [STEP_W-1:0] S_ADD    = 5'd3;
  localparam logic [STEP_W-1:0] S_PARK   = 5'd4;
  localparam logic [STEP_W-1:0] S_SPAN   = 5'd5;
  localparam logic [STEP_W-1:0] S_COMMIT = 5'd6;
  localparam logic [STEP_W-1:0] S_SC_RD  = 5'd7;
  localparam logic [STEP_W-1:0] S_SC_CMP = 5'd8;
  localparam logic [STEP_W-1:0] S_Q_RD   = 5'd9;
  localparam logic [STEP_W-1:0] S_P1_LD  = 5'd10;
  localparam logic [STEP_W-1:0] S_DIV1   = 5'd11;
  localparam logic [STEP_W-1:0] S_P1_ST  = 5'd12;
  localparam logic [STEP_W-1:0] S_P2_LD  = 5'd13;
  localparam logic [STEP_W-1:0] S_DIV2   = 5'd14;
  localparam logic [STEP_W-1:0] S_P2_ST  = 5'd15;
  localparam logic [STEP_W-1:0] S_EMIT   = 5'd16;
  localparam logic [STEP_W-1:0] S_END    = 5'd17;

  function automatic ucw_t urom(input logic [STEP_W-1:0] s);
    ucw_t w;
    case (s)
      S_IDLE:   w = '{op: U_NOP,    jc: J_NO_START,  target: S_IDLE};
      S_RD_BLK: w = '{op: U_RD_BLK, jc: J_NONE,      target: S_IDLE};
      S_CHK:    w = '{op: U_CHK,    jc: J_NONE,      target: S_IDLE};
      S_ADD:    w = '{op: U_ADD,    jc: J_NONE,      target: S_IDLE};
      S_PARK:   w = '{op: U_PARK,   jc: J_NONE,      target: S_IDLE};
      S_SPAN:   w = '{op: U_SPAN,   jc: J_NONE,      target: S_IDLE};
      S_COMMIT: w = '{op: U_COMMIT, jc: J_NONE,      target: S_IDLE};
      S_SC_RD:  w = '{op: U_SC_RD,  jc: J_NONE,      target: S_IDLE};
      S_SC_CMP: w = '{op: U_SC_CMP, jc: J_SCAN_MORE, target: S_SC_RD};
      S_Q_RD:   w = '{op: U_Q_RD,   jc: J_NONE,      target: S_IDLE};
      S_P1_LD:  w = '{op: U_P1_LD,  jc: J_NONE,      target: S_IDLE};
      S_DIV1:   w = '{op: U_DIV,    jc: J_DIV_BUSY,  target: S_DIV1};
      S_P1_ST:  w = '{op: U_P1_ST,  jc: J_NONE,      target: S_IDLE};
      S_P2_LD:  w = '{op: U_P2_LD,  jc: J_NONE,      target: S_IDLE};
      S_DIV2:   w = '{op: U_DIV,    jc: J_DIV_BUSY,  target: S_DIV2};
      S_P2_ST:  w = '{op: U_P2_ST,  jc: J_NONE,      target: S_IDLE};
      S_EMIT:   w = '{op: U_EMIT,   jc: J_OUT_FULL,  target: S_EMIT};
      S_END:    w = '{op: U_NOP,    jc: J_ALWAYS,    target: S_IDLE};
      default:  w = '{op: U_NOP,    jc: J_ALWAYS,    target: S_IDLE};
    endcase
    return w;
  endfunction

  logic [STEP_W-1:0] step_q;
  logic [STEP_W-1:0] step_d;
  ucw_t              cw;
  logic              take;

  assign cw = urom(step_q);

  always_comb begin
    case (cw.jc)
      J_NONE:      take = 1'b0;
      J_ALWAYS:    take = 1'b1;
      J_NO_START:  take = !start_i;
      J_SCAN_MORE: take = stat_i.scan_more;
      J_DIV_BUSY:  take = stat_i.div_busy;
      J_OUT_FULL:  take = out_full_i;
      default:     take = 1'b1;
    endcase
    step_d = take ? cw.target : step_q + 5'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign op_o   = cw.op;
  assign idle_o = step_q == S_IDLE;

endmodule

`default_nettype wire

[sv/igta_dp.sv]
// Datapath: item latch, time accumulators, blocker time memory, scan and percent unit.
`default_nettype none

module igta_dp import igta_pkg::*; #(
  parameter int NUM_BLOCKERS = NUM_BLOCKERS_DEF,
  parameter int TIME_BITS    = TIME_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire uop_e                 op_i,
  input  wire logic                 ld_i,
  input  wire logic [TIME_BITS-1:0] time_us_i,
  input  wire logic [COND_W-1:0]    conditions_i,
  input  wire logic [DUE_W-1:0]     deadline_ms_i,
  input  wire logic [BLK_W-1:0]     query_blocker_i,
  input  wire logic                 enable_i,
  input  wire logic [THR_W-1:0]     throttle_ms_i,
  input  wire logic [GAP_W-1:0]     max_gap_us_i,
  output dp_stat_t                  stat_o,
  output res_t                      res_o
);

  localparam int TB = TIME_BITS;
  localparam int NB = NUM_BLOCKERS;
  localparam int AW = (NB > 1) ? $clog2(NB) : 1;
  localparam logic [BLK_W-1:0] NB_C   = BLK_W'(NB);
  localparam logic [BLK_W-1:0] LAST_C = BLK_W'(NB - 1);

  // item latch
  logic [TB-1:0]     t_q;
  logic [BLK_W-1:0]  blk_q;
  logic [DUE_W-1:0]  due_q;
  logic [BLK_W-1:0]  query_q;

  // persistent state
  logic [TB-1:0]     measured_q;
  logic [TB-1:0]     last_q;
  logic [TB-1:0]     idle_q;
  logic              parked_q;
  logic [CNT_W-1:0]  pcnt_q;
  logic              reason_q;
  logic [NB-1:0]     bt_vld_q;

  // working registers
  logic [TB-1:0]     dt_q;
  logic              ok_q;
  logic [PARK_W-1:0] park_q;
  logic [SPAN_W-1:0] span_q;
  logic              trans_q;
  logic              ent_q;
  logic [TB-1:0]     best_q;
  logic [BLK_W-1:0]  top_q;
  logic [BLK_W-1:0]  sc_idx_q;
  logic [PCT_W-1:0]  bpct_q;
  logic [PCT_W-1:0]  apct_q;

  // blocked time memory, one port
  logic [TB-1:0]     bt_mem [NB];
  logic [TB-1:0]     rdata_q;
  logic [BLK_W-1:0]  rd_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_idx;
  logic              rd_rng;
  logic              wr_en;
  logic [AW-1:0]     wr_idx;
  logic [TB-1:0]     wr_data;

  logic              pass;
  logic [PARK_W-1:0] thr_c;
  logic [PARK_W-1:0] park_c;
  logic [TB-1:0]     span_ext;

  logic              div_ld;
  logic              div_p1;
  logic [TB-1:0]     div_num;
  logic [TB-1:0]     div_den;
  logic              div_busy;
  logic [PCT_W-1:0]  div_pct;

  always_comb begin
    case (op_i)
      U_RD_BLK: rd_addr = blk_q;
      U_SC_RD:  rd_addr = sc_idx_q;
      U_Q_RD:   rd_addr = query_q;
      default:  rd_addr = blk_q;
    endcase
  end

  assign rd_en   = op_i == U_RD_BLK || op_i == U_SC_RD || op_i == U_Q_RD;
  assign rd_idx  = rd_addr[AW-1:0];
  assign rd_rng  = rd_addr < NB_C;
  assign wr_en   = op_i == U_ADD && ok_q && blk_q < NB_C;
  assign wr_idx  = blk_q[AW-1:0];
  assign wr_data = rdata_q + dt_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) bt_mem[wr_idx] <= wr_data;
    if (rd_en) rdata_q <= (rd_rng && bt_vld_q[rd_idx]) ? bt_mem[rd_idx] : '0;
  end

  assign pass     = blk_q == BLK_PASS;
  assign thr_c    = (throttle_ms_i > MAX_PARK_MS) ? MAX_PARK_MS : throttle_ms_i;
  assign park_c   = (DUE_W'(thr_c) > due_q) ? due_q[PARK_W-1:0] : thr_c;
  assign span_ext = TB'(span_q);

  // model state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      measured_q <= '0;
      last_q     <= '0;
      idle_q     <= '0;
      parked_q   <= 1'b0;
      pcnt_q     <= '0;
      reason_q   <= 1'b0;
      bt_vld_q   <= '0;
    end else begin
      case (op_i)
        U_ADD: begin
          if (ok_q) measured_q <= measured_q + dt_q;
          if (wr_en) bt_vld_q[wr_idx] <= 1'b1;
        end
        U_PARK: begin
          parked_q <= pass;
          if (pass) reason_q <= 1'b1;
        end
        U_COMMIT: begin
          if (park_q != '0) begin
            idle_q <= idle_q + span_ext;
            pcnt_q <= pcnt_q + 32'd1;
            last_q <= t_q + span_ext;
          end else begin
            last_q <= t_q;
          end
        end
        default: ;
      endcase
    end
  end

  // scan index is control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_idx_q <= '0;
    end else if (op_i == U_COMMIT) begin
      sc_idx_q <= '0;
    end else if (op_i == U_SC_CMP) begin
      sc_idx_q <= sc_idx_q + 3'd1;
    end
  end

  // item latch and working values
  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      t_q     <= time_us_i;
      blk_q   <= gate(enable_i, conditions_i);
      due_q   <= deadline_ms_i;
      query_q <= query_blocker_i;
    end
    case (op_i)
      U_RD_BLK: dt_q <= t_q - last_q;
      U_CHK:    ok_q <= last_q != '0 && dt_q < TB'(max_gap_us_i);
      U_PARK: begin
        trans_q <= pass != parked_q;
        ent_q   <= pass && !parked_q;
        park_q  <= pass ? park_c : '0;
      end
      U_SPAN:   span_q <= SPAN_W'(park_q) * SPAN_W'(US_PER_MS);
      U_COMMIT: begin
        best_q <= '0;
        top_q  <= BLK_PASS;
      end
      U_SC_CMP: begin
        if (rdata_q > best_q) begin
          best_q <= rdata_q;
          top_q  <= sc_idx_q;
        end
      end
      U_P1_ST:  bpct_q <= div_pct;
      U_P2_ST:  apct_q <= div_pct;
      default: ;
    endcase
  end

  assign div_p1  = op_i == U_P1_LD;
  assign div_ld  = div_p1 || op_i == U_P2_LD;
  assign div_num = div_p1 ? rdata_q : idle_q;
  assign div_den = div_p1 ? measured_q : last_q;

  igta_pdiv #(
    .TIME_BITS(TB)
  ) u_pdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ld_i   (div_ld),
    .step_i (op_i == U_DIV),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .pct_o  (div_pct)
  );

  assign stat_o.div_busy  = div_busy;
  assign stat_o.scan_more = sc_idx_q != LAST_C;

  assign res_o.blocker          = blk_q;
  assign res_o.park_ms          = park_q;
  assign res_o.transition_valid = trans_q;
  assign res_o.entering_park    = ent_q;
  assign res_o.parked           = parked_q;
  assign res_o.park_count       = pcnt_q;
  assign res_o.wake_reason      = reason_q;
  assign res_o.blocked_pct      = bpct_q;
  assign res_o.top_blocker      = top_q;
  assign res_o.asleep_pct       = apct_q;

endmodule

`default_nettype wire

[sv/idle_gate_time_attribution_top.sv]
// Top level of the idle gate time attribution block.
//
// Each input transfer is one loop-end check. A priority gate over the six
// condition flags picks the first blocker; the gap since the previous check is
// charged to that blocker and to the measured total when it is below max_gap_us.
// The block tracks the parked regime, gives the park time as the lesser of the
// clamped throttle and the wake deadline, and reports park count, the queried
// blocker's share, the top blocker and the asleep share (percent, capped at 100).
// Control is a microcoded sequencer: a ROM of control words, one per step,
// drives a plain datapath with one shared bit-serial percent unit and a
// single-port blocker time memory. From one accept to the next, an item goes
// through six steps of attribution and park bookkeeping, a read and a compare
// step per memory entry for the top blocker scan, two bit-serial percent
// divisions (a capped or empty share is set when the division is loaded), and
// eight load, store, emit and idle steps. The result is held in an output
// register; s_axis_tready is high only while the sequencer waits in its idle
// step, and the sequencer stalls on its emit step while the output register
// is still full. The configuration port is always ready and must only be
// written while the block is idle.
`default_nettype none

module idle_gate_time_attribution_top import igta_pkg::*; #(
  parameter int NUM_BLOCKERS = NUM_BLOCKERS_DEF,
  parameter int TIME_BITS    = TIME_BITS_DEF
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  // input items
  input  wire logic                                     s_axis_tvalid,
  output logic                                          s_axis_tready,
  // time_us, conditions[5:0], deadline_ms[15:0], query_blocker[2:0], zero pad
  input  wire logic [((TIME_BITS+COND_W+DUE_W+BLK_W+7)/8)*8-1:0] s_axis_tdata,
  // result items
  output logic                                          m_axis_tvalid,
  input  wire logic                                     m_axis_tready,
  // blocker[2:0], park_ms[9:0], transition_valid, entering_park, parked,
  // park_count[31:0], wake_reason, blocked_pct[6:0], top_blocker[2:0],
  // asleep_pct[6:0], zero pad
  output logic [OUT_W-1:0]                              m_axis_tdata,
  // configuration writes
  input  wire logic                                     cfg_valid_i,
  output logic                                          cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]                     cfg_index_i,
  input  wire logic [CFG_W-1:0]                         cfg_data_i
);

  localparam int TB    = TIME_BITS;
  localparam int C_LO  = TB;
  localparam int D_LO  = C_LO + COND_W;
  localparam int Q_LO  = D_LO + DUE_W;
  localparam int RES_W = $bits(res_t);

  // configuration registers
  logic              enable_q;
  logic [THR_W-1:0]  throttle_q;
  logic [GAP_W-1:0]  max_gap_q;
  logic              cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      throttle_q <= THROTTLE_RST;
      max_gap_q  <= MAX_GAP_RST;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        CFG_ENABLE:   enable_q   <= cfg_data_i[0];
        CFG_THROTTLE: throttle_q <= cfg_data_i[THR_W-1:0];
        CFG_MAX_GAP:  max_gap_q  <= cfg_data_i[GAP_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // sequencer and datapath
  uop_e     op;
  logic     seq_idle;
  logic     in_xfer;
  logic     out_free;
  dp_stat_t dp_stat;
  res_t     res;

  assign s_axis_tready = seq_idle;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // output register
  logic             out_vld_q;
  logic [OUT_W-1:0] out_data_q;
  logic             emit;

  assign out_free = !out_vld_q || m_axis_tready;
  assign emit     = op == U_EMIT && out_free;

  igta_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_xfer),
    .out_full_i (!out_free),
    .stat_i     (dp_stat),
    .op_o       (op),
    .idle_o     (seq_idle)
  );

  igta_dp #(
    .NUM_BLOCKERS (NUM_BLOCKERS),
    .TIME_BITS    (TB)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .ld_i            (in_xfer),
    .time_us_i       (s_axis_tdata[TB-1:0]),
    .conditions_i    (s_axis_tdata[D_LO-1:C_LO]),
    .deadline_ms_i   (s_axis_tdata[Q_LO-1:D_LO]),
    .query_blocker_i (s_axis_tdata[Q_LO+BLK_W-1:Q_LO]),
    .enable_i        (enable_q),
    .throttle_ms_i   (throttle_q),
    .max_gap_us_i    (max_gap_q),
    .stat_o          (dp_stat),
    .res_o           (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  // struct packs blocker in the low bits, as on the bus
  always_ff @(posedge clk_i) begin
    if (emit) out_data_q <= OUT_W'(RES_W'(res));
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire
